/* hdl/rhpd_pkg.sv */
// Shared types, constants and CRC helper for the readout half-packet decoder.
package rhpd_pkg;

  localparam int unsigned WORDS_PER_HALF   = 40;
  localparam int unsigned READOUT_CHANNELS = 38;
  localparam int unsigned POS_W            = $clog2(WORDS_PER_HALF);

  localparam logic [31:0] CRC_POLY         = 32'h04C1_1DB7;
  localparam logic [3:0]  HEAD_TAIL_NIBBLE = 4'h5;

  // Channel index (word position minus one) that carries the calibration channel
  localparam int unsigned CALIB_INDEX  = 19;
  localparam logic [5:0]  CALIB_CHAN   = 6'd36;
  localparam logic [5:0]  CM_CHAN_A    = 6'd37;
  localparam logic [5:0]  CM_CHAN_B    = 6'd38;

  // Output buffer; depth must be a power of two, at least 4
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef enum logic {
    REC_CHANNEL = 1'b0,
    REC_STATUS  = 1'b1
  } rec_kind_e;

  typedef struct packed {
    rec_kind_e          record_kind;
    logic [5:0]         channel_number;
    logic signed [10:0] adc_value;
    logic signed [10:0] adc_previous;
    logic signed [10:0] time_of_arrival;
    logic signed [12:0] time_over_threshold;
    logic [1:0]         tot_flag;
    logic [4:0]         corruption_code;
    logic [11:0]        bunch_counter;
    logic [5:0]         event_counter;
    logic [2:0]         orbit_counter;
    logic               last_of_run;
  } rec_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [31:0]      crc;
    logic [31:0]      header;
  } dec_state_t;

  typedef logic [31:0][31:0] crc_mat_t;

  // Bit-serial CRC of one word from a zero remainder; elaboration only
  function automatic logic [31:0] crc_serial(input logic [31:0] d);
    logic [31:0] s;
    logic        fb;
    s = '0;
    for (int b = 31; b >= 0; b--) begin
      fb = s[31] ^ d[b];
      s  = {s[30:0], 1'b0};
      if (fb) begin
        s = s ^ CRC_POLY;
      end
    end
    return s;
  endfunction

  // Row i holds the input bits that XOR into remainder bit i.
  // Next remainder = M * (remainder ^ word) for a 32-bit word.
  function automatic crc_mat_t crc_row_masks();
    crc_mat_t    m;
    logic [31:0] col;
    m = '0;
    for (int j = 0; j < 32; j++) begin
      col = crc_serial(32'(1) << j);
      for (int i = 0; i < 32; i++) begin
        m[i][j] = col[i];
      end
    end
    return m;
  endfunction

endpackage

/* hdl/readout_half_packet_decoder.sv */
// Top level of the readout half-packet decoder.
// Input stream s_axis carries one 32-bit packet word per transaction; tuser
// marks a header word and restarts the word count and CRC. Word 0 is the
// header, word 1 gives the common-mode channels 37 and 38, the following
// words give one channel record each, and the last word is the CRC that
// closes the packet with a status record.
// Output stream m_axis carries one record per transaction; tuser is the
// record kind and tlast flags the final record caused by one input word.
// The cfg channel writes the characterisation-mode bit; it is always ready.
// Records of an accepted word are decoded combinationally and registered in
// the result buffer before they are offered. Throughput: one word per cycle;
// decoding and the parallel CRC sit between the framing registers and a
// four-entry result buffer, and s_axis_tready drops while that buffer cannot
// take two more records. When the receiver stalls, records wait in the buffer
// and input stops once it holds more than two. Reset clears the buffer, the
// word count and the mode bit; the first word after reset is taken as a header.
module readout_half_packet_decoder import rhpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] data_word
  input  logic        s_axis_tuser_i,   // [0] start_of_packet
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [5:0] channel_number, [16:6] adc_value, [27:17] adc_previous,
  // [38:28] time_of_arrival, [51:39] time_over_threshold, [53:52] tot_flag,
  // [58:54] corruption_code, [70:59] bunch_counter, [76:71] event_counter,
  // [79:77] orbit_counter
  output logic [79:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,   // [0] record_kind
  output logic        m_axis_tlast_o,   // last_of_run
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i        // characterisation_mode
);

  dec_state_t state_q, state_d;
  logic       char_mode_q;
  logic       in_acc;
  logic       space_ok;
  logic [1:0] num_rec;
  logic [1:0] push_num;
  rec_t       rec_a, rec_b, out_rec;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = space_ok;
  assign in_acc          = s_axis_tvalid_i && space_ok;
  assign push_num        = in_acc ? num_rec : 2'd0;

  rhpd_decode u_decode (
    .word_i      (s_axis_tdata_i),
    .sop_i       (s_axis_tuser_i),
    .char_mode_i (char_mode_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .num_rec_o   (num_rec),
    .rec_a_o     (rec_a),
    .rec_b_o     (rec_b)
  );

  rhpd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_num_i  (push_num),
    .push_a_i    (rec_a),
    .push_b_i    (rec_b),
    .space_ok_o  (space_ok),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_rec_o   (out_rec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      char_mode_q <= 1'b0;
    end else begin
      if (in_acc) begin
        state_q <= state_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        char_mode_q <= cfg_data_i;
      end
    end
  end

  assign m_axis_tdata_o = {out_rec.orbit_counter, out_rec.event_counter,
                           out_rec.bunch_counter, out_rec.corruption_code,
                           out_rec.tot_flag, out_rec.time_over_threshold,
                           out_rec.time_of_arrival, out_rec.adc_previous,
                           out_rec.adc_value, out_rec.channel_number};
  assign m_axis_tuser_o = out_rec.record_kind;
  assign m_axis_tlast_o = out_rec.last_of_run;

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pos <= POS_W'(WORDS_PER_HALF - 1))
    else $error("word position out of range");

  a_status_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !s_axis_tuser_i && (state_q.pos == POS_W'(WORDS_PER_HALF - 1)))
      |=> (state_q.pos == '0))
    else $error("word count did not restart after CRC word");

  a_header_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser_i) |=> (state_q.pos == POS_W'(1)))
    else $error("header word did not restart the packet");

  a_header_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_axis_tuser_i || (state_q.pos == '0))) |-> (num_rec == 2'd0))
    else $error("header word produced a record");

endmodule

/* hdl/rhpd_decode.sv */
// Word decoder: framing position, parallel CRC-32 and record field extraction.
module rhpd_decode import rhpd_pkg::*; (
  input  logic [31:0] word_i,
  input  logic        sop_i,
  input  logic        char_mode_i,
  input  dec_state_t  state_i,
  output dec_state_t  state_o,
  output logic [1:0]  num_rec_o,
  output rec_t        rec_a_o,
  output rec_t        rec_b_o
);

  localparam crc_mat_t CrcRows = crc_row_masks();

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] idx;
  logic [31:0]      crc_in;
  logic [31:0]      crc_next;
  logic [4:0]       hdr_corr;
  logic             hdr_bad;
  logic [5:0]       chan;
  logic [9:0]       tot_raw;
  logic             tot_present;
  rec_t             base;
  rec_t             chrec;

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      crc_next[i] = ^(CrcRows[i] & crc_in);
    end
  end

  always_comb begin
    pos    = sop_i ? '0 : state_i.pos;
    crc_in = (pos == '0) ? word_i : (state_i.crc ^ word_i);

    hdr_bad  = !((state_i.header[31:28] == HEAD_TAIL_NIBBLE) &&
                 (state_i.header[3:0] == HEAD_TAIL_NIBBLE));
    hdr_corr = {state_i.header[6:4], 1'b0, hdr_bad};

    base                     = '0;
    base.record_kind         = REC_CHANNEL;
    base.corruption_code     = hdr_corr;
    base.bunch_counter       = state_i.header[27:16];
    base.event_counter       = state_i.header[15:10];
    base.orbit_counter       = state_i.header[9:7];

    // channel renumbering: calibration channel sits in the middle of the run
    idx = pos - POS_W'(1);
    if (idx <= POS_W'(CALIB_INDEX - 1)) begin
      chan = 6'(idx - POS_W'(1));
    end else if (idx == POS_W'(CALIB_INDEX)) begin
      chan = CALIB_CHAN;
    end else begin
      chan = 6'(idx - POS_W'(2));
    end

    chrec                 = base;
    chrec.channel_number  = chan;
    chrec.time_of_arrival = {1'b0, word_i[9:0]};
    chrec.last_of_run     = 1'b1;
    tot_raw               = word_i[19:10];
    if (!char_mode_i && (chan != CALIB_CHAN)) begin
      chrec.tot_flag     = word_i[31:30];
      chrec.adc_previous = {1'b0, word_i[29:20]};
      if (!word_i[31]) begin
        chrec.adc_value = {1'b0, word_i[19:10]};
        tot_present     = 1'b0;
      end else begin
        chrec.adc_value = '1;
        tot_present     = 1'b1;
      end
    end else begin
      chrec.tot_flag     = 2'b00;
      chrec.adc_previous = '1;
      chrec.adc_value    = {1'b0, word_i[29:20]};
      tot_present        = 1'b1;
    end
    // compressed tot: bit 9 set means the low nine bits count in steps of 8
    if (!tot_present) begin
      chrec.time_over_threshold = '1;
    end else if (tot_raw[9]) begin
      chrec.time_over_threshold = {1'b0, tot_raw[8:0], 3'b000};
    end else begin
      chrec.time_over_threshold = {3'b000, tot_raw};
    end

    state_o   = state_i;
    num_rec_o = 2'd0;
    rec_a_o   = chrec;
    rec_b_o   = chrec;

    if (pos == '0) begin
      state_o.header = word_i;
      state_o.crc    = crc_next;
      state_o.pos    = POS_W'(1);
    end else if (pos >= POS_W'(WORDS_PER_HALF - 1)) begin
      rec_a_o                     = base;
      rec_a_o.record_kind         = REC_STATUS;
      rec_a_o.adc_value           = '1;
      rec_a_o.adc_previous        = '1;
      rec_a_o.time_of_arrival     = '1;
      rec_a_o.time_over_threshold = '1;
      rec_a_o.corruption_code     = hdr_corr | {3'b000, (state_i.crc != word_i), 1'b0};
      rec_a_o.last_of_run         = 1'b1;
      num_rec_o                   = 2'd1;
      state_o.pos                 = '0;
    end else begin
      state_o.crc = crc_next;
      state_o.pos = pos + POS_W'(1);
      if (pos == POS_W'(1)) begin
        rec_a_o                = base;
        rec_a_o.channel_number = CM_CHAN_A;
        rec_a_o.adc_value      = {1'b0, word_i[19:10]};
        rec_b_o                = base;
        rec_b_o.channel_number = CM_CHAN_B;
        rec_b_o.adc_value      = {1'b0, word_i[9:0]};
        rec_b_o.last_of_run    = 1'b1;
        num_rec_o              = 2'd2;
      end else if (pos <= POS_W'(READOUT_CHANNELS)) begin
        num_rec_o = 2'd1;
      end
    end
  end

endmodule

/* hdl/rhpd_out_fifo.sv */
// Small result buffer: takes up to two records a cycle, hands out one while out_ready_i is high.
module rhpd_out_fifo import rhpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_num_i,
  input  rec_t       push_a_i,
  input  rec_t       push_b_i,
  output logic       space_ok_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rec_t       out_rec_o
);

  rec_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d;
  logic [FIFO_PTR_W-1:0] rd_q, rd_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  pop;

  assign out_valid_o = (count_q != '0);
  assign out_rec_o   = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  // room for the worst case of two records from the next word
  assign space_ok_o  = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    wr_d    = wr_q + FIFO_PTR_W'(push_num_i);
    rd_d    = rd_q + FIFO_PTR_W'(pop);
    count_d = count_q + FIFO_CNT_W'(push_num_i) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[wr_q] <= push_a_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[wr_q + FIFO_PTR_W'(1)] <= push_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result buffer count overflow");

  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_num_i != 2'd0) |-> (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2)))
    else $error("push into result buffer without room");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != FIFO_CNT_W'(FIFO_DEPTH)) |-> ((wr_q - rd_q) == count_q[FIFO_PTR_W-1:0]))
    else $error("result buffer pointers disagree with count");

endmodule

/* verif/readout_half_packet_decoder_tb.sv */
// Self-checking testbench for the readout half-packet decoder.
module readout_half_packet_decoder_tb;
  import rhpd_pkg::*;

  localparam int LIMIT_CYCLES = 200000;

  // Tracks the decoder state, predicts the records of each accepted word and
  // checks the records that leave the block in order.
  class half_packet_scoreboard;
    logic [5:0]  word_pos;
    logic [31:0] crc_rem;
    logic [31:0] header_word;
    bit          char_mode;
    rec_t        pending_records[$];
    int          mismatches;

    function new();
      word_pos    = '0;
      crc_rem     = '0;
      header_word = '0;
      char_mode   = 1'b0;
      mismatches  = 0;
    endfunction

    // MSB-first CRC-32 over one word, no reflection
    function logic [31:0] crc_step(logic [31:0] c, logic [31:0] w);
      logic top;
      for (int b = 31; b >= 0; b--) begin
        top = c[31];
        c   = {c[30:0], 1'b0};
        if (top ^ w[b]) begin
          c = c ^ CRC_POLY;
        end
      end
      return c;
    endfunction

    function rec_t make_rec(rec_kind_e kind, logic [5:0] chan, int adc, int prev, int toa,
                            int tot, logic [1:0] flag, logic [4:0] corr, logic last);
      rec_t r;
      r.record_kind         = kind;
      r.channel_number      = chan;
      r.adc_value           = 11'(adc);
      r.adc_previous        = 11'(prev);
      r.time_of_arrival     = 11'(toa);
      r.time_over_threshold = 13'(tot);
      r.tot_flag            = flag;
      r.corruption_code     = corr;
      r.bunch_counter       = header_word[27:16];
      r.event_counter       = header_word[15:10];
      r.orbit_counter       = header_word[9:7];
      r.last_of_run         = last;
      return r;
    endfunction

    function void take_word(logic [31:0] w, logic sop);
      int unsigned pos;
      int unsigned idx;
      logic [5:0]  chan;
      int          adc;
      int          prev;
      int          toa;
      int          tot;
      logic [1:0]  flag;
      logic [4:0]  corr;
      pos = sop ? 0 : word_pos;
      if (pos == 0) begin
        header_word = w;
        crc_rem     = crc_step('0, w);
        word_pos    = 6'd1;
        return;
      end
      corr = {header_word[6:4], 1'b0,
              !(header_word[31:28] == HEAD_TAIL_NIBBLE && header_word[3:0] == HEAD_TAIL_NIBBLE)};
      if (pos >= WORDS_PER_HALF - 1) begin
        if (crc_rem != w) begin
          corr[1] = 1'b1;
        end
        pending_records.push_back(make_rec(REC_STATUS, 6'd0, -1, -1, -1, -1, 2'd0, corr, 1'b1));
        word_pos = '0;
        return;
      end
      crc_rem  = crc_step(crc_rem, w);
      word_pos = 6'(pos + 1);
      if (pos == 1) begin
        pending_records.push_back(make_rec(REC_CHANNEL, CM_CHAN_A, int'(w[19:10]), 0, 0, 0,
                                           2'd0, corr, 1'b0));
        pending_records.push_back(make_rec(REC_CHANNEL, CM_CHAN_B, int'(w[9:0]), 0, 0, 0,
                                           2'd0, corr, 1'b1));
      end else if (pos <= READOUT_CHANNELS) begin
        idx = pos - 1;
        if (idx <= CALIB_INDEX - 1) begin
          chan = 6'(idx - 1);
        end else if (idx == CALIB_INDEX) begin
          chan = CALIB_CHAN;
        end else begin
          chan = 6'(idx - 2);
        end
        adc  = -1;
        prev = -1;
        tot  = -1;
        flag = 2'd0;
        toa  = int'(w[9:0]);
        if (!char_mode && chan != CALIB_CHAN) begin
          flag = w[31:30];
          prev = int'(w[29:20]);
          if (flag <= 2'd1) begin
            adc = int'(w[19:10]);
          end else begin
            tot = int'(w[19:10]);
          end
        end else begin
          adc = int'(w[29:20]);
          tot = int'(w[19:10]);
        end
        // compressed tot: bit 9 set means the low nine bits count in steps of 8
        if (tot >= 0 && tot[9]) begin
          tot = (tot & 'h1ff) << 3;
        end
        pending_records.push_back(make_rec(REC_CHANNEL, chan, adc, prev, toa, tot, flag,
                                           corr, 1'b1));
      end
    endfunction

    function string show(rec_t r);
      return $sformatf({"kind=%0d ch=%0d adc=%0d prev=%0d toa=%0d tot=%0d flag=%0d ",
                        "corr=%h bx=%0d ev=%0d orb=%0d last=%0d"},
                       r.record_kind, r.channel_number, r.adc_value, r.adc_previous,
                       r.time_of_arrival, r.time_over_threshold, r.tot_flag,
                       r.corruption_code, r.bunch_counter, r.event_counter,
                       r.orbit_counter, r.last_of_run);
    endfunction

    function void match_record(rec_t got);
      rec_t want;
      bit   bad;
      if (pending_records.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected record: %s", show(got));
        end
        mismatches++;
        return;
      end
      want = pending_records.pop_front();
      bad  = want.record_kind != got.record_kind
          || want.channel_number != got.channel_number
          || want.adc_value != got.adc_value
          || want.adc_previous != got.adc_previous
          || want.time_of_arrival != got.time_of_arrival
          || want.time_over_threshold != got.time_over_threshold
          || want.tot_flag != got.tot_flag
          || want.corruption_code != got.corruption_code
          || want.bunch_counter != got.bunch_counter
          || want.event_counter != got.event_counter
          || want.orbit_counter != got.orbit_counter
          || want.last_of_run != got.last_of_run;
      if (bad) begin
        if (mismatches < 10) begin
          $display("record mismatch\n  expected %s\n  actual   %s", show(want), show(got));
        end
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_n     = 1'b0;
  logic        s_valid   = 1'b0;
  logic [31:0] s_data    = '0;
  logic        s_sop     = 1'b0;
  logic        m_ready   = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_data  = 1'b0;
  logic        hold_rx   = 1'b0;
  logic        pressure_on = 1'b0;

  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [79:0] m_axis_tdata_o;
  wire         m_axis_tuser_o;
  wire         m_axis_tlast_o;
  wire         cfg_ready_o;

  int send_idle = 0;
  int recv_idle = 0;
  int words_sent = 0;
  int cycles = 0;

  half_packet_scoreboard sb;

  readout_half_packet_decoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_sop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("readout_half_packet_decoder regression: fail");
      $finish;
    end
  end

  // Result side: check each transaction, then decide readiness for the next edge
  always @(posedge clk_i) begin : rx_side
    rec_t got;
    if (rst_n && m_axis_tvalid_o && m_ready) begin
      got.record_kind         = rec_kind_e'(m_axis_tuser_o);
      got.channel_number      = m_axis_tdata_o[5:0];
      got.adc_value           = m_axis_tdata_o[16:6];
      got.adc_previous        = m_axis_tdata_o[27:17];
      got.time_of_arrival     = m_axis_tdata_o[38:28];
      got.time_over_threshold = m_axis_tdata_o[51:39];
      got.tot_flag            = m_axis_tdata_o[53:52];
      got.corruption_code     = m_axis_tdata_o[58:54];
      got.bunch_counter       = m_axis_tdata_o[70:59];
      got.event_counter       = m_axis_tdata_o[76:71];
      got.orbit_counter       = m_axis_tdata_o[79:77];
      got.last_of_run         = m_axis_tlast_o;
      sb.match_record(got);
    end
    m_ready <= !hold_rx && ($urandom_range(99) >= recv_idle);
  end

  // Long receiver stall so the output buffer fills and the input backs up
  initial begin : rx_hold
    wait (pressure_on);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  task automatic send_word(input logic [31:0] w, input logic sop);
    while ($urandom_range(99) < send_idle) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= w;
    s_sop   <= sop;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.take_word(w, sop);
    words_sent++;
  endtask

  // Sends a header and n_words-1 more words; a full packet ends with its CRC word.
  // fixed_head puts edge-case channel words first and leaves the header unmarked.
  task automatic send_packet(input logic [31:0] hdr, input int n_words, input bit bad_crc,
                             input bit fixed_head);
    logic [31:0] crc;
    logic [31:0] w;
    logic        sop;
    logic [31:0] edge_words [6];
    edge_words = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'hBFFF_FFFF,
                   32'hC007_FC00, 32'h8008_0000};
    if (fixed_head) begin
      sop = 1'b0;
    end else begin
      // an open packet needs the marker; otherwise leave it off now and then
      sop = (sb.word_pos != 0) || ($urandom_range(3) != 0);
    end
    crc = sb.crc_step('0, hdr);
    send_word(hdr, sop);
    for (int k = 1; k < n_words; k++) begin
      if (k == WORDS_PER_HALF - 1) begin
        w = bad_crc ? crc ^ (32'd1 << $urandom_range(31)) : crc;
      end else begin
        w   = (fixed_head && k <= 6) ? edge_words[k-1] : $urandom();
        crc = sb.crc_step(crc, w);
      end
      send_word(w, 1'b0);
    end
  endtask

  task automatic run_phase(input int n_items);
    int          stop_at;
    int          r;
    logic [31:0] rnd;
    logic [31:0] good_hdr;
    stop_at = words_sent + n_items;
    while (words_sent < stop_at) begin
      r        = $urandom_range(99);
      rnd      = $urandom();
      good_hdr = {HEAD_TAIL_NIBBLE, rnd[27:4], HEAD_TAIL_NIBBLE};
      if (r < 82) begin
        send_packet(good_hdr, WORDS_PER_HALF, r >= 70, 1'b0);
      end else if (r < 88) begin
        send_packet(rnd, WORDS_PER_HALF, 1'($urandom_range(1)), 1'b0);
      end else if (r < 95) begin
        send_packet(good_hdr, $urandom_range(WORDS_PER_HALF - 1, 1), 1'b0, 1'b0);
      end else begin
        repeat ($urandom_range(4, 1)) send_word($urandom(), $urandom_range(7) == 0);
      end
    end
    s_valid <= 1'b0;
  endtask

  task automatic write_mode(input bit mode);
    while (sb.pending_records.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    sb.char_mode = mode;
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    write_mode(1'b0);

    // edge-case channel words, counters and flags at their maxima, no marker after reset
    send_packet(32'h5FFF_FFF5, WORDS_PER_HALF, 1'b0, 1'b1);
    // bad head/tail nibbles, packet cut short and dropped by the next header
    send_packet(32'h0000_0000, 5, 1'b0, 1'b0);
    send_packet(32'h5000_0005, WORDS_PER_HALF, 1'b1, 1'b0);
    s_valid <= 1'b0;

    send_idle = 6;
    recv_idle = 84;
    write_mode(1'b1);
    run_phase(420);

    send_idle = 84;
    recv_idle = 6;
    write_mode(1'b0);
    run_phase(420);

    send_idle = 0;
    recv_idle = 0;
    write_mode(1'b1);
    pressure_on = 1'b1;
    run_phase(260);
    write_mode(1'b0);
    run_phase(160);

    while (sb.pending_records.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("readout_half_packet_decoder regression: pass");
    end else begin
      $display("readout_half_packet_decoder regression: fail");
    end
    $finish;
  end

endmodule
